>>> hdl/priority_interrupt_controller_top_defines.svh
// Assertion macros for the priority interrupt controller
`ifndef PRIORITY_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
// Check an implication on every clock edge outside reset
`define PIC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a one-hot vector outside reset
`define PIC_ONEHOT(label, clk, rst_n, vec, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) $onehot(vec)) else $error(msg);
`endif

>>> hdl/pic_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pic_pkg
// Types, constants and source tables of the priority interrupt controller.
// ---------------------------------------------------------------------------
package pic_pkg;

	localparam int unsigned NUM_SOURCES_DEF = 64;
	localparam int unsigned NUM_PRIO_WORDS_DEF = 8;
	localparam int unsigned TAB_DEPTH = 51;
	localparam int unsigned TAB_IDX_W = 6;

	localparam logic [2:0] OP_READ  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_SRC   = 3'd2;
	localparam logic [2:0] OP_PIN   = 3'd3;
	localparam logic [2:0] OP_NMI   = 3'd4;
	localparam logic [2:0] OP_ACK   = 3'd5;

	localparam logic [1:0] VAR_SMALL   = 2'd0;
	localparam logic [1:0] VAR_DEFAULT = 2'd1;
	localparam logic [1:0] VAR_OLDER   = 2'd2;
	localparam logic [1:0] VAR_LARGE   = 2'd3;

	localparam logic [31:0] IPR_BASE_NEW = 32'hFFFF8348;
	localparam logic [31:0] ICR_ADDR_NEW = 32'hFFFF8358;
	localparam logic [31:0] ISR_ADDR_NEW = 32'hFFFF835A;
	localparam logic [31:0] IPR_BASE_OLD = 32'h05FFFF84;
	localparam logic [31:0] ICR_ADDR_OLD = 32'h05FFFF8E;
	localparam logic [15:0] ICR_MASK_SMALL = 16'h01F3;
	localparam logic [15:0] ICR_MASK_FULL  = 16'h01FF;
	localparam logic [15:0] ICR_NMI_RISE   = 16'h0100;
	localparam logic [3:0]  NIBBLE_MASK    = 4'hF;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] address;
		logic        byte_access;
		logic [15:0] write_data;
		logic [5:0]  source_index;
		logic        line_state;
		logic [2:0]  pin_number;
		logic [7:0]  ack_vector;
	} pic_in_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [3:0]  irq_level;
		logic [7:0]  irq_vector;
		logic        irq_from_pin;
		logic        nmi_fired;
	} pic_out_t;

	// One source table entry
	typedef struct packed {
		logic [5:0] id;
		logic [7:0] vec;
		logic [3:0] word;
		logic [3:0] shift;
	} pic_src_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic apply;
		logic scan_clear;
		logic scan_step;
		logic finish;
	} pic_cmd_t;

	typedef struct packed {
		logic scan_last;
	} pic_sts_t;

	function automatic pic_src_t mk(input int id, input int vec, input int w, input int sh);
		pic_src_t s;
		s.id = 6'(id);
		s.vec = 8'(vec);
		s.word = 4'(w);
		s.shift = 4'(sh);
		return s;
	endfunction

	function automatic logic [5:0] tab_count(input logic [1:0] v);
		logic [5:0] c;
		case (v)
			VAR_OLDER: c = 6'd39;
			VAR_LARGE: c = 6'd51;
			default:   c = 6'd34;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pin_bit(input logic [1:0] v, input logic [2:0] n);
		logic [7:0] b;
		b = 8'h80 >> n;
		if ((v == VAR_SMALL || v == VAR_DEFAULT) && (n == 3'd4 || n == 3'd5))
			b = 8'h00;
		return b;
	endfunction

	function automatic pic_src_t src_small(input logic [5:0] i);
		pic_src_t s;
		case (i)
			6'd0: s = mk(0,64,0,12);   6'd1: s = mk(1,65,0,8);
			6'd2: s = mk(2,66,0,4);    6'd3: s = mk(3,67,0,0);
			6'd4: s = mk(6,70,1,4);    6'd5: s = mk(7,71,1,0);
			6'd6: s = mk(8,72,2,12);   6'd7: s = mk(9,76,2,8);
			6'd8: s = mk(12,88,3,12);  6'd9: s = mk(13,89,3,12);
			6'd10: s = mk(14,90,3,12); 6'd11: s = mk(15,91,3,12);
			6'd12: s = mk(16,92,3,8);  6'd13: s = mk(17,96,3,4);
			6'd14: s = mk(18,97,3,4);  6'd15: s = mk(19,100,3,0);
			6'd16: s = mk(20,101,3,0); 6'd17: s = mk(21,104,4,12);
			6'd18: s = mk(22,105,4,12); 6'd19: s = mk(23,108,4,8);
			6'd20: s = mk(24,109,4,8); 6'd21: s = mk(35,128,5,4);
			6'd22: s = mk(36,129,5,4); 6'd23: s = mk(37,130,5,4);
			6'd24: s = mk(38,131,5,4); 6'd25: s = mk(39,132,5,0);
			6'd26: s = mk(40,133,5,0); 6'd27: s = mk(41,134,5,0);
			6'd28: s = mk(42,135,5,0); 6'd29: s = mk(44,136,6,12);
			6'd30: s = mk(47,144,6,4); 6'd31: s = mk(48,148,6,0);
			6'd32: s = mk(49,152,7,12); 6'd33: s = mk(50,153,7,12);
			default: s = mk(0,0,0,0);
		endcase
		return s;
	endfunction

	function automatic pic_src_t src_older(input logic [5:0] i);
		pic_src_t s;
		case (i)
			6'd0: s = mk(0,64,0,12);   6'd1: s = mk(1,65,0,8);
			6'd2: s = mk(2,66,0,4);    6'd3: s = mk(3,67,0,0);
			6'd4: s = mk(4,68,1,12);   6'd5: s = mk(5,69,1,8);
			6'd6: s = mk(6,70,1,4);    6'd7: s = mk(7,71,1,0);
			6'd8: s = mk(8,72,2,12);   6'd9: s = mk(9,74,2,12);
			6'd10: s = mk(10,76,2,8);  6'd11: s = mk(11,78,2,8);
			6'd12: s = mk(12,80,2,4);  6'd13: s = mk(13,81,2,4);
			6'd14: s = mk(16,82,2,4);  6'd15: s = mk(17,84,2,0);
			6'd16: s = mk(18,85,2,0);  6'd17: s = mk(19,86,2,0);
			6'd18: s = mk(21,88,3,12); 6'd19: s = mk(22,89,3,12);
			6'd20: s = mk(23,90,3,12); 6'd21: s = mk(25,92,3,8);
			6'd22: s = mk(26,93,3,8);  6'd23: s = mk(29,94,3,8);
			6'd24: s = mk(30,96,3,4);  6'd25: s = mk(31,97,3,4);
			6'd26: s = mk(34,98,3,4);  6'd27: s = mk(35,100,3,0);
			6'd28: s = mk(36,101,3,0); 6'd29: s = mk(37,102,3,0);
			6'd30: s = mk(38,103,3,0); 6'd31: s = mk(39,104,4,12);
			6'd32: s = mk(40,105,4,12); 6'd33: s = mk(41,106,4,12);
			6'd34: s = mk(42,107,4,12); 6'd35: s = mk(43,108,4,8);
			6'd36: s = mk(44,109,4,8); 6'd37: s = mk(49,112,4,4);
			6'd38: s = mk(50,113,4,4);
			default: s = mk(0,0,0,0);
		endcase
		return s;
	endfunction

	function automatic pic_src_t src_large(input logic [5:0] i);
		pic_src_t s;
		case (i)
			6'd0: s = mk(0,64,0,12);   6'd1: s = mk(1,65,0,8);
			6'd2: s = mk(2,66,0,4);    6'd3: s = mk(3,67,0,0);
			6'd4: s = mk(4,68,1,12);   6'd5: s = mk(5,69,1,8);
			6'd6: s = mk(6,70,1,4);    6'd7: s = mk(7,71,1,0);
			6'd8: s = mk(8,72,2,12);   6'd9: s = mk(9,76,2,8);
			6'd10: s = mk(10,80,2,4);  6'd11: s = mk(11,84,2,0);
			6'd12: s = mk(12,88,3,12); 6'd13: s = mk(13,89,3,12);
			6'd14: s = mk(14,90,3,12); 6'd15: s = mk(15,91,3,12);
			6'd16: s = mk(16,92,3,8);  6'd17: s = mk(17,96,3,4);
			6'd18: s = mk(18,97,3,4);  6'd19: s = mk(19,100,3,0);
			6'd20: s = mk(20,101,3,0); 6'd21: s = mk(21,104,4,12);
			6'd22: s = mk(22,105,4,12); 6'd23: s = mk(23,108,4,8);
			6'd24: s = mk(24,109,4,8); 6'd25: s = mk(25,112,4,4);
			6'd26: s = mk(26,113,4,4); 6'd27: s = mk(27,114,4,4);
			6'd28: s = mk(28,115,4,4); 6'd29: s = mk(29,116,4,0);
			6'd30: s = mk(30,120,5,12); 6'd31: s = mk(31,121,5,12);
			6'd32: s = mk(32,122,5,12); 6'd33: s = mk(33,123,5,12);
			6'd34: s = mk(34,124,5,8); 6'd35: s = mk(35,128,5,4);
			6'd36: s = mk(36,129,5,4); 6'd37: s = mk(37,130,5,4);
			6'd38: s = mk(38,131,5,4); 6'd39: s = mk(39,132,5,0);
			6'd40: s = mk(40,133,5,0); 6'd41: s = mk(41,134,5,0);
			6'd42: s = mk(42,135,5,0); 6'd43: s = mk(44,136,6,12);
			6'd44: s = mk(45,137,6,12); 6'd45: s = mk(46,140,6,8);
			6'd46: s = mk(47,144,6,4); 6'd47: s = mk(48,148,6,0);
			6'd48: s = mk(49,152,7,12); 6'd49: s = mk(50,153,7,12);
			6'd50: s = mk(51,156,7,8);
			default: s = mk(0,0,0,0);
		endcase
		return s;
	endfunction

	// Table entry of a variant; the default variant differs from the small one only in the vector of entry 29
	function automatic pic_src_t src_entry(input logic [1:0] v, input logic [5:0] i);
		pic_src_t s;
		case (v)
			VAR_OLDER: s = src_older(i);
			VAR_LARGE: s = src_large(i);
			VAR_DEFAULT: begin
				s = src_small(i);
				if (i == 6'd29) s.vec = 8'd138;
			end
			default: s = src_small(i);
		endcase
		return s;
	endfunction

endpackage

>>> hdl/pic_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pic_ctrl
// Sequencer: apply a beat, scan the source table, then present the result.
// ---------------------------------------------------------------------------
`include "priority_interrupt_controller_top_defines.svh"
module pic_ctrl
	import pic_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  pic_sts_t sts,
	output pic_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DONE  = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign accept    = in_valid && !in_stall;

	// Command decode
	always_comb begin
		cmd = '0;
		cmd.apply = accept;
		cmd.scan_clear = accept;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_DONE);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_SCAN;
			ST_SCAN: if (sts.scan_last) state_d = ST_DONE;
			ST_DONE: state_d = ST_OUT;
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	`PIC_ONEHOT(a_state_onehot, clk, arst_n, state_q, "state not one-hot")
	`PIC_ASSERT(a_out_holds, clk, arst_n, (out_valid && out_stall) |=> out_valid, "result dropped")
	`PIC_ASSERT(a_no_accept_busy, clk, arst_n, out_valid |-> in_stall, "accept while presenting")

endmodule

>>> hdl/pic_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pic_datapath
// Register file, request state and the sequential priority scan.
// ---------------------------------------------------------------------------
module pic_datapath
	import pic_pkg::*;
#(
	parameter int unsigned NUM_SOURCES = NUM_SOURCES_DEF,
	parameter int unsigned NUM_PRIO_WORDS = NUM_PRIO_WORDS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic [1:0] variant,
	input  pic_in_t  in_data,
	input  pic_cmd_t cmd,
	output pic_sts_t sts,
	output pic_out_t out_data
);

	localparam int unsigned WIDX_W = $clog2(NUM_PRIO_WORDS);

	logic [15:0] prio_q [NUM_PRIO_WORDS];
	logic [15:0] icr_q, isr_q;
	logic [NUM_SOURCES-1:0] req_q;
	logic [7:0]  pin_low_q;
	logic        nmi_high_q;
	logic [15:0] rd_q;
	logic        nmi_q;
	logic [5:0]  idx_q;
	logic [3:0]  best_lvl_q;
	logic [7:0]  best_vec_q;
	pic_out_t    out_q;

	// Address decode
	logic [31:0] prio_base, icr_addr, isr_addr, base_addr, eff_addr, off;
	logic [4:0]  ipr_cnt;
	logic        has_isr;
	logic [15:0] ctrl_wmask;
	logic        ipr_hit, icr_hit, isr_hit;
	logic [3:0]  widx;
	logic [15:0] old_word, wr_word;

	always_comb begin
		if (variant == VAR_OLDER) begin
			prio_base = IPR_BASE_OLD; icr_addr = ICR_ADDR_OLD; isr_addr = '0;
			has_isr = 1'b0; ipr_cnt = 5'd5;
		end else begin
			prio_base = IPR_BASE_NEW; icr_addr = ICR_ADDR_NEW; isr_addr = ISR_ADDR_NEW;
			has_isr = 1'b1; ipr_cnt = 5'd8;
		end
		if (ipr_cnt > 5'(NUM_PRIO_WORDS)) ipr_cnt = 5'(NUM_PRIO_WORDS);
		ctrl_wmask = (variant == VAR_OLDER || variant == VAR_LARGE) ? ICR_MASK_FULL
			: ICR_MASK_SMALL;
		base_addr = {in_data.address[31:1], 1'b0};
		eff_addr = in_data.byte_access ? base_addr : in_data.address;
		off = eff_addr - prio_base;
		ipr_hit = (eff_addr >= prio_base) && (off < {26'd0, ipr_cnt, 1'b0});
		widx = off[4:1];
		icr_hit = !ipr_hit && (eff_addr == icr_addr);
		isr_hit = !ipr_hit && !icr_hit && has_isr && (eff_addr == isr_addr);
		if (ipr_hit) old_word = prio_q[widx[WIDX_W-1:0]];
		else if (icr_hit) old_word = icr_q;
		else if (isr_hit) old_word = isr_q;
		else old_word = '0;
		if (!in_data.byte_access) wr_word = in_data.write_data;
		else if (in_data.address[0]) wr_word = {old_word[15:8], in_data.write_data[7:0]};
		else wr_word = {in_data.write_data[7:0], old_word[7:0]};
	end

	// Apply one beat to the state
	logic [15:0] icr_d, isr_d;
	logic [NUM_SOURCES-1:0] req_d;
	logic [7:0]  pin_low_d;
	logic [15:0] rd_d;
	logic        nmi_d;
	pic_src_t    sel_src;
	logic [7:0]  bit8;
	logic [15:0] clr;
	logic [2:0]  pn;

	always_comb begin
		icr_d = icr_q; isr_d = isr_q; req_d = req_q; pin_low_d = pin_low_q;
		rd_d = '0; nmi_d = 1'b0;
		pn = in_data.pin_number;
		sel_src = src_entry(variant, in_data.source_index);
		clr = '0;
		bit8 = '0;
		case (in_data.op)
			OP_READ: begin
				if (!in_data.byte_access) rd_d = old_word;
				else if (in_data.address[0]) rd_d = {8'd0, old_word[7:0]};
				else rd_d = {8'd0, old_word[15:8]};
			end
			OP_WRITE: begin
				if (icr_hit) begin
					icr_d = wr_word & ctrl_wmask;
					for (int n = 0; n < 8; n++) begin
						bit8 = pin_bit(variant, 3'(n));
						if (bit8 != 0 && (icr_d[7:0] & bit8) == 0) begin
							isr_d[7-n] = pin_low_q[n];
							if (n < NUM_SOURCES) req_d[n] = pin_low_q[n];
						end
					end
				end else if (isr_hit) begin
					clr = isr_q & ~wr_word;
					for (int n = 0; n < 8; n++) begin
						bit8 = pin_bit(variant, 3'(n));
						if (bit8 != 0 && clr[7-n] && icr_q[7-n]) begin
							isr_d[7-n] = 1'b0;
							if (n < NUM_SOURCES) req_d[n] = 1'b0;
						end
					end
				end
			end
			OP_SRC: begin
				if (in_data.source_index < tab_count(variant) && 32'(sel_src.id) < NUM_SOURCES)
					req_d[sel_src.id] = in_data.line_state;
			end
			OP_PIN: begin
				bit8 = pin_bit(variant, pn);
				if (bit8 != 0) begin
					pin_low_d[pn] = in_data.line_state;
					if (icr_q[3'd7 - pn]) begin
						if (in_data.line_state && !pin_low_q[pn]) isr_d[3'd7 - pn] = 1'b1;
					end else begin
						isr_d[3'd7 - pn] = in_data.line_state;
					end
					if (32'(pn) < NUM_SOURCES) req_d[pn] = isr_d[3'd7 - pn];
				end
			end
			OP_NMI: begin
				nmi_d = (in_data.line_state != nmi_high_q)
					&& (in_data.line_state == ((icr_q & ICR_NMI_RISE) != 0));
			end
			OP_ACK: begin
				if (in_data.ack_vector[7:3] == 5'b01000) begin
					bit8 = pin_bit(variant, in_data.ack_vector[2:0]);
					if (bit8 != 0 && icr_q[3'd7 - in_data.ack_vector[2:0]]) begin
						isr_d[3'd7 - in_data.ack_vector[2:0]] = 1'b0;
						if (32'(in_data.ack_vector[2:0]) < NUM_SOURCES)
							req_d[in_data.ack_vector[2:0]] = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	// Scan step: one table entry a cycle
	pic_src_t   scan_src;
	logic [3:0] scan_lvl;
	logic [15:0] scan_word;
	logic       scan_ok;
	always_comb begin
		scan_src = src_entry(variant, idx_q);
		scan_word = (32'(scan_src.word) < NUM_PRIO_WORDS)
			? prio_q[scan_src.word[WIDX_W-1:0]] : '0;
		scan_lvl = 4'(scan_word >> scan_src.shift) & NIBBLE_MASK;
		scan_ok = (idx_q < tab_count(variant)) && (32'(scan_src.id) < NUM_SOURCES)
			&& req_q[scan_src.id] && (32'(scan_src.word) < NUM_PRIO_WORDS);
	end
	assign sts.scan_last = (idx_q == tab_count(variant) - 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PRIO_WORDS; i++) prio_q[i] <= '0;
			icr_q <= '0; isr_q <= '0; req_q <= '0; pin_low_q <= '0; nmi_high_q <= 1'b0;
		end else if (cmd.apply) begin
			if (in_data.op == OP_WRITE && ipr_hit) prio_q[widx[WIDX_W-1:0]] <= wr_word;
			if (in_data.op == OP_NMI) nmi_high_q <= in_data.line_state;
			icr_q <= icr_d; isr_q <= isr_d; req_q <= req_d; pin_low_q <= pin_low_d;
		end
	end

	// Scan and result registers
	always_ff @(posedge clk) begin
		if (cmd.scan_clear) begin
			idx_q <= '0; best_lvl_q <= '0; best_vec_q <= '0; rd_q <= rd_d; nmi_q <= nmi_d;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 6'd1;
			if (scan_ok && scan_lvl > best_lvl_q) begin
				best_lvl_q <= scan_lvl; best_vec_q <= scan_src.vec;
			end
		end
		if (cmd.finish) begin
			out_q.read_data <= rd_q;
			out_q.irq_level <= best_lvl_q;
			out_q.irq_vector <= best_vec_q;
			out_q.irq_from_pin <= (best_vec_q[7:3] == 5'b01000);
			out_q.nmi_fired <= nmi_q;
		end
	end
	assign out_data = out_q;

endmodule

>>> hdl/priority_interrupt_controller_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_interrupt_controller_top
// Priority interrupt controller with per-variant source tables.
// ---------------------------------------------------------------------------
// Channel   Handshake            Payload
// in        in_valid / in_stall  pic_in_t
// out       out_valid/ out_stall pic_out_t
// cfg       cfg_valid/ cfg_ready chip variant, 2 bits
//
// An item steps through accepting and applying the beat, a priority scan of the
// N entries of the variant's source table (34, 39 or 51), registering the result
// and the result beat.
// Reset leaves variant 1 and clears the priority, ICR and ISR registers, the pin
// and NMI line state and the requests; scan and result registers are not reset.
// A stalled result holds; no new beat is taken until it leaves.
module priority_interrupt_controller_top
	import pic_pkg::*;
#(
	parameter int unsigned NUM_SOURCES = NUM_SOURCES_DEF,
	parameter int unsigned NUM_PRIO_WORDS = NUM_PRIO_WORDS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  pic_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output pic_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [1:0] cfg_data
);

	pic_cmd_t   cmd;
	pic_sts_t   sts;
	logic [1:0] variant_q;

	assign cfg_ready = 1'b1;

	// Hold the chip variant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) variant_q <= VAR_DEFAULT;
		else if (cfg_valid && cfg_ready) variant_q <= cfg_data;
	end

	pic_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
	);

	pic_datapath #(.NUM_SOURCES(NUM_SOURCES), .NUM_PRIO_WORDS(NUM_PRIO_WORDS)) u_dp (
		.clk, .arst_n, .variant(variant_q), .in_data, .cmd, .sts, .out_data
	);

endmodule
